FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the particle step core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: src/pdm_pkg.sv
// ----------------------------------------------------------------------------
// pdm_pkg
// Types, constants and helpers for the particle drag motion step.
// ----------------------------------------------------------------------------
package pdm_pkg;

	// Divide-by-constant unit: dividend width, bits per cycle, divisor
	localparam int unsigned DIV_W     = 40;
	localparam int unsigned DIV_DIGIT = 8;
	localparam int unsigned DIV_STEPS = DIV_W / DIV_DIGIT;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [5:0]  DIV_K     = 6'd25;

	localparam logic [30:0]        T_MAX = 31'h7FFF_FFFF;
	localparam logic signed [31:0] V0Y   = 32'sd45875;

	// Configuration register indexes
	localparam logic [2:0] CFG_DENSITY   = 3'd0;
	localparam logic [2:0] CFG_VISCOSITY = 3'd1;
	localparam logic [2:0] CFG_START_VX  = 3'd2;
	localparam logic [2:0] CFG_ACCEL_X   = 3'd3;
	localparam logic [2:0] CFG_START_X   = 3'd4;
	localparam logic [2:0] CFG_START_Y   = 3'd5;

	typedef struct packed {
		logic [30:0]        density;
		logic [30:0]        viscosity;
		logic signed [31:0] start_vel_x;
		logic signed [31:0] accel_x;
		logic [15:0]        start_x;
		logic [15:0]        start_y;
	} cfg_t;

	typedef struct packed {
		logic [15:0]        pos_x;
		logic [15:0]        pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic               laminar;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_MXX,
		S_MYY,
		S_PP,
		S_NN,
		S_PV0,
		S_PV1,
		S_PV2,
		S_PV3,
		S_PVA,
		S_DEC,
		S_AX,
		S_LAMD,
		S_TP0,
		S_TP1,
		S_TPA,
		S_TX,
		S_DIVW,
		S_ACC,
		S_W,
		S_T1,
		S_T2,
		S_T3,
		S_POS,
		S_DONE
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		logic signed [31:0] r;
		if (v > 49'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -49'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = $signed(v[31:0]);
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] r;
		r = v[31] ? (~v + 32'd1) : v;
		return r;
	endfunction

endpackage

FILE: src/pdm_mul.sv
// ----------------------------------------------------------------------------
// pdm_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pdm_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= {32'b0, a} * {32'b0, b};
	end

endmodule

FILE: src/pdm_div25.sv
// ----------------------------------------------------------------------------
// pdm_div25
// Iterative divide by the constant 25, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module pdm_div25 (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pdm_pkg::DIV_W-1:0] dividend,
	output logic                      done,
	output logic [pdm_pkg::DIV_W-1:0] quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [pdm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [pdm_pkg::DIV_W-1:0]     dvd_q;
	logic [pdm_pkg::DIV_W-1:0]     quo_q;
	logic [4:0]                    rem_q;
	logic [4:0]                    rem_d;
	logic [pdm_pkg::DIV_DIGIT-1:0] qbits;

	// Long division, one dividend bit per inner step, remainder stays below 25
	always_comb begin
		logic [5:0] r6;
		logic [4:0] rem;
		rem   = rem_q;
		qbits = '0;
		for (int i = 0; i < pdm_pkg::DIV_DIGIT; i++) begin
			r6 = {rem, dvd_q[pdm_pkg::DIV_W-1-i]};
			if (r6 >= pdm_pkg::DIV_K) begin
				rem = 5'(r6 - pdm_pkg::DIV_K);
				qbits[pdm_pkg::DIV_DIGIT-1-i] = 1'b1;
			end else begin
				rem = r6[4:0];
			end
		end
		rem_d = rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pdm_pkg::DIV_CNT_W'(pdm_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << pdm_pkg::DIV_DIGIT;
			rem_q <= rem_d;
			quo_q <= {quo_q[pdm_pkg::DIV_W-pdm_pkg::DIV_DIGIT-1:0], qbits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: src/pdm_core.sv
// ----------------------------------------------------------------------------
// pdm_core
// Step sequencer and datapath around the shared multiplier and divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdm_core (
	input  logic           clk,
	input  logic           arst_n,
	input  pdm_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [30:0]    in_dt,
	input  logic           out_free,
	output logic           res_valid,
	output pdm_pkg::res_t  res
);

	pdm_pkg::state_t state_q, state_d;

	logic               axis_q;
	logic [30:0]        t_q;
	logic signed [31:0] vx_q, vy_q;
	logic [63:0]        v2_q, pp_q;
	logic [66:0]        rhs_q;
	logic [95:0]        acc_q;
	logic               lam_q;
	logic [15:0]        vsq_hi_q;
	logic [45:0]        d_q;
	logic               big_q;
	logic signed [31:0] a_q;
	logic [46:0]        mw_q;
	logic [15:0]        t1_q;
	logic [16:0]        lo17_q;
	logic [15:0]        posx_q, posy_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_s1;
	logic        div_start, div_done;
	logic [pdm_pkg::DIV_W-1:0] div_quo;
	logic        in_fire;

	logic signed [31:0] v_cur, a0_cur, v0_cur;
	logic [31:0]        m_cur;
	logic [15:0]        s0_cur;
	logic [66:0]        lam9;
	logic [67:0]        rhs25;
	logic [60:0]        pv;
	logic [65:0]        t27;
	logic [56:0]        xq;
	logic [33:0]        dcap;
	logic signed [48:0] a0e, dce, asum;
	logic signed [48:0] wsig, v0e, vel_sum;
	logic signed [31:0] vel_new;
	logic [31:0]        sum_t;
	logic [16:0]        t2sum;
	logic [15:0]        t2, t1w, t2w, pos_new;

	pdm_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (prod_s1)
	);

	pdm_div25 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (xq[pdm_pkg::DIV_W-1:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Per-axis operands
	assign v_cur  = axis_q ? vy_q : vx_q;
	assign m_cur  = pdm_pkg::mag32(v_cur);
	assign a0_cur = axis_q ? 32'sd0 : cfg.accel_x;
	assign v0_cur = axis_q ? pdm_pkg::V0Y : cfg.start_vel_x;
	assign s0_cur = axis_q ? cfg.start_y : cfg.start_x;

	// Constant scalings as shift-add
	assign lam9  = {prod_s1, 3'b0} + {3'b0, prod_s1};
	assign rhs25 = {prod_s1, 4'b0} + {1'b0, prod_s1, 3'b0} + {4'b0, prod_s1};
	assign pv    = acc_q[76:16];
	assign t27   = {1'b0, pv, 4'b0} + {2'b0, pv, 3'b0} + {4'b0, pv, 1'b0} + {5'b0, pv};
	assign xq    = t27[65:9];

	// Any drag at or above 2^32 saturates the acceleration whatever its sign
	assign dcap = (big_q || (|d_q[45:32])) ? 34'h1_0000_0000 : {2'b0, d_q[31:0]};
	assign a0e  = {{17{a0_cur[31]}}, a0_cur};
	assign dce  = {15'b0, dcap};
	assign asum = v_cur[31] ? (a0e + dce) : (a0e - dce);

	assign wsig    = a_q[31] ? -$signed({2'b0, mw_q}) : $signed({2'b0, mw_q});
	assign v0e     = {{17{v0_cur[31]}}, v0_cur};
	assign vel_sum = v0e + wsig;
	assign vel_new = pdm_pkg::sat32(vel_sum);

	assign t2sum   = lo17_q + prod_s1[16:0];
	assign t2      = t2sum[16:1];
	assign t1w     = v0_cur[31] ? (~t1_q + 16'd1) : t1_q;
	assign t2w     = a_q[31] ? (~t2 + 16'd1) : t2;
	assign pos_new = s0_cur + t1w + t2w;

	assign sum_t   = {1'b0, t_q} + {1'b0, in_dt};
	assign in_fire = in_valid && in_ready;

	// Multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			pdm_pkg::S_MXX: begin
				mul_a = pdm_pkg::mag32(vx_q);
				mul_b = pdm_pkg::mag32(vx_q);
			end
			pdm_pkg::S_MYY: begin
				mul_a = pdm_pkg::mag32(vy_q);
				mul_b = pdm_pkg::mag32(vy_q);
			end
			pdm_pkg::S_PP: begin
				mul_a = {1'b0, cfg.density};
				mul_b = {1'b0, cfg.density};
			end
			pdm_pkg::S_NN: begin
				mul_a = {1'b0, cfg.viscosity};
				mul_b = {1'b0, cfg.viscosity};
			end
			pdm_pkg::S_PV0: begin
				mul_a = pp_q[31:0];
				mul_b = v2_q[31:0];
			end
			pdm_pkg::S_PV1: begin
				mul_a = pp_q[31:0];
				mul_b = v2_q[63:32];
			end
			pdm_pkg::S_PV2: begin
				mul_a = pp_q[63:32];
				mul_b = v2_q[31:0];
			end
			pdm_pkg::S_PV3: begin
				mul_a = pp_q[63:32];
				mul_b = v2_q[63:32];
			end
			pdm_pkg::S_AX: begin
				mul_a = lam_q ? {1'b0, cfg.viscosity} : m_cur;
				mul_b = m_cur;
			end
			pdm_pkg::S_TP0: begin
				mul_a = {1'b0, cfg.density};
				mul_b = prod_s1[47:16];
			end
			pdm_pkg::S_TP1: begin
				mul_a = {1'b0, cfg.density};
				mul_b = {16'b0, vsq_hi_q};
			end
			pdm_pkg::S_W: begin
				mul_a = pdm_pkg::mag32(a_q);
				mul_b = {1'b0, t_q};
			end
			pdm_pkg::S_T1: begin
				mul_a = pdm_pkg::mag32(v0_cur);
				mul_b = {1'b0, t_q};
			end
			pdm_pkg::S_T2: begin
				mul_a = mw_q[31:0];
				mul_b = {1'b0, t_q};
			end
			pdm_pkg::S_T3: begin
				mul_a = {17'b0, mw_q[46:32]};
				mul_b = {1'b0, t_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d   = state_q;
		in_ready  = (state_q == pdm_pkg::S_IDLE);
		div_start = (state_q == pdm_pkg::S_TX);
		res_valid = (state_q == pdm_pkg::S_DONE) && out_free;
		unique case (state_q)
			pdm_pkg::S_IDLE: if (in_valid) state_d = pdm_pkg::S_MXX;
			pdm_pkg::S_MXX:  state_d = pdm_pkg::S_MYY;
			pdm_pkg::S_MYY:  state_d = pdm_pkg::S_PP;
			pdm_pkg::S_PP:   state_d = pdm_pkg::S_NN;
			pdm_pkg::S_NN:   state_d = pdm_pkg::S_PV0;
			pdm_pkg::S_PV0:  state_d = pdm_pkg::S_PV1;
			pdm_pkg::S_PV1:  state_d = pdm_pkg::S_PV2;
			pdm_pkg::S_PV2:  state_d = pdm_pkg::S_PV3;
			pdm_pkg::S_PV3:  state_d = pdm_pkg::S_PVA;
			pdm_pkg::S_PVA:  state_d = pdm_pkg::S_DEC;
			pdm_pkg::S_DEC:  state_d = pdm_pkg::S_AX;
			pdm_pkg::S_AX:   state_d = lam_q ? pdm_pkg::S_LAMD : pdm_pkg::S_TP0;
			pdm_pkg::S_LAMD: state_d = pdm_pkg::S_ACC;
			pdm_pkg::S_TP0:  state_d = pdm_pkg::S_TP1;
			pdm_pkg::S_TP1:  state_d = pdm_pkg::S_TPA;
			pdm_pkg::S_TPA:  state_d = pdm_pkg::S_TX;
			pdm_pkg::S_TX:   state_d = pdm_pkg::S_DIVW;
			pdm_pkg::S_DIVW: if (div_done) state_d = pdm_pkg::S_ACC;
			pdm_pkg::S_ACC:  state_d = pdm_pkg::S_W;
			pdm_pkg::S_W:    state_d = pdm_pkg::S_T1;
			pdm_pkg::S_T1:   state_d = pdm_pkg::S_T2;
			pdm_pkg::S_T2:   state_d = pdm_pkg::S_T3;
			pdm_pkg::S_T3:   state_d = pdm_pkg::S_POS;
			pdm_pkg::S_POS:  state_d = axis_q ? pdm_pkg::S_DONE : pdm_pkg::S_AX;
			pdm_pkg::S_DONE: if (out_free) state_d = pdm_pkg::S_IDLE;
			default: state_d = pdm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdm_pkg::S_IDLE;
			axis_q  <= 1'b0;
			t_q     <= '0;
			vx_q    <= '0;
			vy_q    <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				t_q <= sum_t[31] ? pdm_pkg::T_MAX : sum_t[30:0];
			end
			if (state_q == pdm_pkg::S_DEC) begin
				axis_q <= 1'b0;
			end else if (state_q == pdm_pkg::S_POS) begin
				axis_q <= 1'b1;
			end
			if (state_q == pdm_pkg::S_T2) begin
				if (axis_q) begin
					vy_q <= vel_new;
				end else begin
					vx_q <= vel_new;
				end
			end
		end
	end

	// Datapath: a state that uses a product takes the one issued in the state before
	always_ff @(posedge clk) begin
		unique case (state_q)
			pdm_pkg::S_MYY:  v2_q   <= prod_s1;
			pdm_pkg::S_PP:   v2_q   <= v2_q + prod_s1;
			pdm_pkg::S_NN:   pp_q   <= prod_s1;
			pdm_pkg::S_PV0:  rhs_q  <= rhs25[66:0];
			pdm_pkg::S_PV1:  acc_q  <= {64'b0, prod_s1[63:32]};
			pdm_pkg::S_PV2:  acc_q  <= acc_q + {32'b0, prod_s1};
			pdm_pkg::S_PV3:  acc_q  <= acc_q + {32'b0, prod_s1};
			pdm_pkg::S_PVA:  acc_q  <= acc_q + {prod_s1, 32'b0};
			pdm_pkg::S_DEC:  lam_q  <= (acc_q < {29'b0, rhs_q});
			pdm_pkg::S_LAMD: begin
				d_q   <= lam9[66:21];
				big_q <= 1'b0;
			end
			pdm_pkg::S_TP0:  vsq_hi_q <= prod_s1[63:48];
			pdm_pkg::S_TP1:  acc_q    <= {32'b0, prod_s1};
			pdm_pkg::S_TPA:  acc_q    <= acc_q + {prod_s1, 32'b0};
			pdm_pkg::S_TX:   big_q    <= |xq[56:pdm_pkg::DIV_W];
			pdm_pkg::S_DIVW: if (div_done) d_q <= {6'b0, div_quo};
			pdm_pkg::S_ACC:  a_q    <= pdm_pkg::sat32(asum);
			pdm_pkg::S_T1:   mw_q   <= prod_s1[62:16];
			pdm_pkg::S_T2:   t1_q   <= prod_s1[47:32];
			pdm_pkg::S_T3:   lo17_q <= prod_s1[48:32];
			pdm_pkg::S_POS: begin
				if (axis_q) begin
					posy_q <= pos_new;
				end else begin
					posx_q <= pos_new;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.pos_x   = posx_q;
	assign res.pos_y   = posy_q;
	assign res.vel_x   = vx_q;
	assign res.vel_y   = vy_q;
	assign res.laminar = lam_q;

	`ASSERT_CLK(a_accept_leaves_idle, in_fire |=> state_q != pdm_pkg::S_IDLE, "accept did not start a step")
	`ASSERT_CLK(a_time_monotone, in_fire |=> t_q >= $past(t_q), "elapsed time went backward")
	`ASSERT_NEVER(a_div_done_stray, div_done && state_q != pdm_pkg::S_DIVW, "divider finished unexpectedly")

endmodule

FILE: src/particle_drag_motion_step_top.sv
// ----------------------------------------------------------------------------
// particle_drag_motion_step_top
// One sand grain in a viscous fluid, advanced one time step per input word.
// ----------------------------------------------------------------------------
// Each input word is a time step (unsigned Q16.16) that is added to the
// saturating elapsed time; the block then picks linear or quadratic drag from
// the stored velocity, forms the acceleration per axis, and returns one output
// word with the new x/y grid position (wrapping), the new Q16.16 velocity and
// the drag regime flag on tuser. A turbulent step takes longer than a
// laminar one, and the next word is accepted in the cycle after the result
// word is handed to the output register. Every product goes through one
// shared 32 x 32 multiplier in sequence, and the quadratic drag also passes
// a divide-by-25 unit that yields eight quotient bits per cycle. s_tready is
// low while a step is in progress; a finished word waits in the output
// register, so the next step may be accepted before it is taken.
// Configuration writes are taken at any time on their own channel but belong
// in idle periods.
// ----------------------------------------------------------------------------
module particle_drag_motion_step_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [30:0] dt, [31] zero
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,    // [15:0] pos_x, [31:16] pos_y,
	                                // [63:32] vel_x_out, [95:64] vel_y_out
	output logic        m_tuser,    // [0] laminar
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	pdm_pkg::cfg_t cfg_q;
	pdm_pkg::res_t res;
	pdm_pkg::res_t out_q;
	logic          res_valid;
	logic          m_tvalid_q;
	logic          out_free;

	// Configuration registers always take a write
	assign cfg_ready = 1'b1;

	// Decode the register index; indexes past the last register drop the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.density     <= 31'd0;
			cfg_q.viscosity   <= 31'd65536;
			cfg_q.start_vel_x <= 32'sd6554;
			cfg_q.accel_x     <= 32'sd642908;
			cfg_q.start_x     <= 16'd0;
			cfg_q.start_y     <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pdm_pkg::CFG_DENSITY:   cfg_q.density     <= cfg_data[30:0];
				pdm_pkg::CFG_VISCOSITY: cfg_q.viscosity   <= cfg_data[30:0];
				pdm_pkg::CFG_START_VX:  cfg_q.start_vel_x <= $signed(cfg_data);
				pdm_pkg::CFG_ACCEL_X:   cfg_q.accel_x     <= $signed(cfg_data);
				pdm_pkg::CFG_START_X:   cfg_q.start_x     <= cfg_data[15:0];
				pdm_pkg::CFG_START_Y:   cfg_q.start_y     <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// The output register is free when empty or when its word leaves now
	assign out_free = !m_tvalid_q || m_tready;

	pdm_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_dt        (s_tdata[30:0]),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Hold the result word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.vel_y, out_q.vel_x, out_q.pos_y, out_q.pos_x};
	assign m_tuser  = out_q.laminar;

endmodule

FILE: test/tb_particle_drag_motion_step_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_particle_drag_motion_step_top
// Self-checking bench for the particle drag motion step block.
// ----------------------------------------------------------------------------
// A short table of directed steps and register writes runs first. A long
// random run follows, with the registers reloaded every 80 steps and before the closing phase. Each
// accepted time step is fed to a bit-exact grain predictor kept in the bench.
// Every output word is compared field by field against the oldest prediction.
// Both streams idle at random. The elapsed time is driven to saturation only
// in the closing phase, because reset is applied once and saturation sticks.
// ----------------------------------------------------------------------------
module tb_particle_drag_motion_step_top;

	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;
	localparam int         STALL_LIMIT  = 2000;

	typedef enum logic {ROW_STEP, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		logic [2:0]    index;     // register index for ROW_CFG
		logic [31:0]   value;     // time step or register data
		bit            typed;     // expected word given in the row
		pdm_pkg::res_t want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	// Shadow registers and grain state of the predictor
	longint unsigned density, viscosity, elapsed;
	longint          vel0_x, drive_x, grain_vx, grain_vy;
	logic [15:0]     origin_x, origin_y;

	pdm_pkg::res_t pending_words[$];
	int   errors;
	int   words_seen;
	int   laminar_seen;
	int   idle_cycles;
	bit   quiet_sink;
	row_t plan[$];

	particle_drag_motion_step_top DUT (.*);

	always #5 clk = ~clk;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	// trunc(a * t) in Q16.16, rounding the magnitude down
	function automatic longint times_elapsed(longint a, longint unsigned t);
		longint r;
		r = longint'((magnitude(a) * t) >> 16);
		return a < 0 ? -r : r;
	endfunction

	function automatic logic [15:0] grain_pos(logic [15:0] s0, longint v0, longint a,
			longint unsigned t);
		longint unsigned lin, quad;
		longint          w;
		logic [127:0]    prod;
		logic [15:0]     lin16, quad16;
		lin    = (magnitude(v0) * t) >> 32;
		w      = times_elapsed(a, t);
		prod   = 128'(magnitude(w)) * 128'(t);
		quad   = 64'(prod >> 33);
		lin16  = v0 < 0 ? 16'(-lin) : 16'(lin);
		quad16 = w < 0 ? 16'(-quad) : 16'(quad);
		return s0 + lin16 + quad16;
	endfunction

	function automatic longint drag_accel(longint a0, longint v, bit lam);
		longint unsigned m, d, vsq, pv;
		m = magnitude(v);
		if (lam) begin
			d = 64'((128'(viscosity * m) * 9) >> 21);
		end else begin
			vsq = (m * m) >> 16;
			pv  = 64'((128'(density) * 128'(vsq)) >> 16);
			d   = 64'((128'(pv) * 27) / 12800);
		end
		return v < 0 ? clamp32(a0 + longint'(d)) : clamp32(a0 - longint'(d));
	endfunction

	// Advance the grain by one time step and return the word it should produce
	function automatic pdm_pkg::res_t advance_grain(logic [30:0] step);
		pdm_pkg::res_t   r;
		bit              lam;
		logic [127:0]    lhs, rhs;
		longint unsigned mx, my;
		longint          acc_x, acc_y;
		elapsed += step;
		if (elapsed > 64'h7FFF_FFFF)
			elapsed = 64'h7FFF_FFFF;
		mx    = magnitude(grain_vx);
		my    = magnitude(grain_vy);
		lhs   = 128'(density * density) * 128'(mx * mx + my * my);
		rhs   = (128'(viscosity * viscosity) * 25) << 32;
		lam   = lhs < rhs;
		acc_x = drag_accel(drive_x, grain_vx, lam);
		acc_y = drag_accel(0, grain_vy, lam);
		grain_vx  = clamp32(vel0_x + times_elapsed(acc_x, elapsed));
		grain_vy  = clamp32(longint'(pdm_pkg::V0Y) + times_elapsed(acc_y, elapsed));
		r.pos_x   = grain_pos(origin_x, vel0_x, acc_x, elapsed);
		r.pos_y   = grain_pos(origin_y, longint'(pdm_pkg::V0Y), acc_y, elapsed);
		r.vel_x   = grain_vx[31:0];
		r.vel_y   = grain_vy[31:0];
		r.laminar = lam;
		return r;
	endfunction

	// Drop the input, hold a register write until the block has drained, then mirror it
	task automatic write_reg(logic [2:0] index, logic [31:0] value);
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			pdm_pkg::CFG_DENSITY:   density   = value[30:0];
			pdm_pkg::CFG_VISCOSITY: viscosity = value[30:0];
			pdm_pkg::CFG_START_VX:  vel0_x    = longint'($signed(value));
			pdm_pkg::CFG_ACCEL_X:   drive_x   = longint'($signed(value));
			pdm_pkg::CFG_START_X:   origin_x  = value[15:0];
			pdm_pkg::CFG_START_Y:   origin_y  = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one time step; a zero gap keeps tvalid high into the next word
	task automatic send_step(logic [30:0] step, bit calm, bit typed, pdm_pkg::res_t want);
		int            gap;
		pdm_pkg::res_t got;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, step};
		do @(posedge clk); while (!s_tready);
		got = advance_grain(step);
		if (typed && got != want) begin
			$display("%0t: table row disagrees with predictor: table %h predictor %h",
				$time, want, got);
			errors++;
		end
		pending_words.push_back(typed ? want : got);
	endtask

	task automatic load_random_config();
		logic [31:0] v;
		for (int i = pdm_pkg::CFG_DENSITY; i <= pdm_pkg::CFG_START_Y; i++) begin
			case ($urandom_range(0, 3))
				0: v = 32'h0000_0000;
				1: v = 32'hFFFF_FFFF;
				2: v = $urandom;
				default: v = $urandom_range(0, 32'h0003_FFFF);
			endcase
			// sign of the signed registers chosen independently of magnitude
			if (i == pdm_pkg::CFG_START_VX || i == pdm_pkg::CFG_ACCEL_X)
				v = $urandom_range(0, 1) ? v : -v;
			// viscosity of zero is covered by the table
			if (i == pdm_pkg::CFG_VISCOSITY && v[30:0] == 0)
				v = 32'd1;
			write_reg(3'(i), v);
		end
	endtask

	// Output side: stall at random, compare each word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		static int hold = 0;
		pdm_pkg::res_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{pos_x: m_tdata[15:0], pos_y: m_tdata[31:16],
					vel_x: m_tdata[63:32], vel_y: m_tdata[95:64], laminar: m_tuser};
				words_seen++;
				laminar_seen += m_tuser;
				if (pending_words.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual %h", $time, got);
					errors++;
				end else begin
					want = pending_words.pop_front();
					if (got.pos_x != want.pos_x)
						$display("%0t: pos_x expected %h actual %h", $time, want.pos_x, got.pos_x);
					if (got.pos_y != want.pos_y)
						$display("%0t: pos_y expected %h actual %h", $time, want.pos_y, got.pos_y);
					if (got.vel_x != want.vel_x)
						$display("%0t: vel_x expected %h actual %h", $time, want.vel_x, got.vel_x);
					if (got.vel_y != want.vel_y)
						$display("%0t: vel_y expected %h actual %h", $time, want.vel_y, got.vel_y);
					if (got.laminar != want.laminar)
						$display("%0t: laminar expected %b actual %b", $time,
							want.laminar, got.laminar);
					if (got != want)
						errors++;
				end
				hold = quiet_sink ? 0 : $urandom_range(0, 17);
			end else if (hold > 0) begin
				hold--;
			end
			m_tready <= (hold == 0);
		end
	end

	// Watchdog: end the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		pdm_pkg::res_t none;
		none = '0;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = pdm_pkg::CFG_DENSITY;
		cfg_data = '0;
		errors = 0;
		words_seen = 0;
		laminar_seen = 0;
		idle_cycles = 0;
		quiet_sink = 1'b0;
		density = 0;
		viscosity = 65536;
		vel0_x = 6554;
		drive_x = 642908;
		origin_x = '0;
		origin_y = '0;
		elapsed = 0;
		grain_vx = 0;
		grain_vy = 0;

		// Directed table: reset state, register extremes, zero viscosity,
		// unused indexes, and both drag regimes
		plan = '{
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'd0, 1'b1,
				'{pos_x: 16'd0, pos_y: 16'd0, vel_x: 32'sd6554, vel_y: 32'sd45875,
				laminar: 1'b1}},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'd1, 1'b0, none},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'h0001_0000, 1'b0, none},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'h0003_0000, 1'b0, none},
			'{ROW_CFG, pdm_pkg::CFG_DENSITY, 32'hFFFF_FFFF, 1'b0, none},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'h0001_0000, 1'b0, none},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'h0000_8000, 1'b0, none},
			'{ROW_CFG, pdm_pkg::CFG_VISCOSITY, 32'h0000_0000, 1'b0, none},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'h0001_0000, 1'b0, none},
			'{ROW_CFG, pdm_pkg::CFG_VISCOSITY, 32'hFFFF_FFFF, 1'b0, none},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'd1000, 1'b0, none},
			'{ROW_CFG, pdm_pkg::CFG_START_VX, 32'h8000_0000, 1'b0, none},
			'{ROW_CFG, pdm_pkg::CFG_ACCEL_X, 32'h8000_0000, 1'b0, none},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'h0001_0000, 1'b0, none},
			'{ROW_CFG, pdm_pkg::CFG_START_VX, 32'h7FFF_FFFF, 1'b0, none},
			'{ROW_CFG, pdm_pkg::CFG_ACCEL_X, 32'h7FFF_FFFF, 1'b0, none},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'h0001_0000, 1'b0, none},
			'{ROW_CFG, pdm_pkg::CFG_START_X, 32'h0000_FFFF, 1'b0, none},
			'{ROW_CFG, pdm_pkg::CFG_START_Y, 32'h0000_FFFF, 1'b0, none},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'h0005_0000, 1'b0, none},
			'{ROW_CFG, CFG_SPARE_LO, 32'hFFFF_FFFF, 1'b0, none},
			'{ROW_CFG, CFG_SPARE_HI, 32'h1234_5678, 1'b0, none},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'd0, 1'b0, none},
			'{ROW_CFG, pdm_pkg::CFG_DENSITY, 32'h0000_0001, 1'b0, none},
			'{ROW_STEP, pdm_pkg::CFG_DENSITY, 32'h0002_0000, 1'b0, none}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].index, plan[i].value);
			else
				send_step(plan[i].value[30:0], 1'b0, plan[i].typed, plan[i].want);
		end

		// Random run: small steps keep the elapsed time well below saturation
		for (int n = 0; n < 1050; n++) begin
			if (n % 80 == 0)
				load_random_config();
			quiet_sink = (n / 150) % 3 == 1;
			send_step($urandom_range(0, 7) == 0 ? 31'($urandom_range(0, 1 << 20))
				: 31'($urandom_range(0, 1 << 16)), (n / 150) % 3 == 2, 1'b0, none);
		end

		// Closing phase: full-range steps drive the elapsed time into saturation
		load_random_config();
		send_step(31'h7FFF_FFFF, 1'b0, 1'b0, none);
		for (int n = 0; n < 24; n++)
			send_step(31'($urandom), n < 12, 1'b0, none);
		s_tvalid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Checked %0d output words, %0d laminar and %0d turbulent,",
			words_seen, laminar_seen, words_seen - laminar_seen);
		$display("over register extremes, random settings and a saturated clock.");
		if (errors == 0 && pending_words.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: particle_drag_motion_step_top.f
+incdir+src
src/pdm_pkg.sv
src/pdm_mul.sv
src/pdm_div25.sv
src/pdm_core.sv
src/particle_drag_motion_step_top.sv
test/tb_particle_drag_motion_step_top.sv
